// File: src/kmc_pkg.sv
package kmc_pkg;

  localparam int unsigned MaxBurst = 7;

  // event kinds
  localparam logic [2:0] FUNC_HOST    = 3'd0;
  localparam logic [2:0] FUNC_MAKE    = 3'd1;
  localparam logic [2:0] FUNC_BREAK   = 3'd2;
  localparam logic [2:0] FUNC_MOTION  = 3'd3;
  localparam logic [2:0] FUNC_PRESS   = 3'd4;
  localparam logic [2:0] FUNC_RELEASE = 3'd5;
  localparam logic [2:0] FUNC_STICK   = 3'd6;
  localparam logic [2:0] FUNC_POLL    = 3'd7;

  // mouse modes
  localparam logic [1:0] MM_OFF = 2'd0;
  localparam logic [1:0] MM_REL = 2'd1;
  localparam logic [1:0] MM_ABS = 2'd2;
  localparam logic [1:0] MM_KEY = 2'd3;

  // host command codes
  localparam logic [7:0] CMD_BTN_ACTION = 8'h07;
  localparam logic [7:0] CMD_REL_MOUSE  = 8'h08;
  localparam logic [7:0] CMD_ABS_MOUSE  = 8'h09;
  localparam logic [7:0] CMD_KEY_MOUSE  = 8'h0a;
  localparam logic [7:0] CMD_THRESH     = 8'h0b;
  localparam logic [7:0] CMD_SCALE      = 8'h0c;
  localparam logic [7:0] CMD_ABS_READ   = 8'h0d;
  localparam logic [7:0] CMD_ABS_LOAD   = 8'h0e;
  localparam logic [7:0] CMD_Y_BOTTOM   = 8'h0f;
  localparam logic [7:0] CMD_Y_TOP      = 8'h10;
  localparam logic [7:0] CMD_RESUME     = 8'h11;
  localparam logic [7:0] CMD_MOUSE_OFF  = 8'h12;
  localparam logic [7:0] CMD_PAUSE      = 8'h13;
  localparam logic [7:0] CMD_JOY_EVENT  = 8'h14;
  localparam logic [7:0] CMD_JOY_INT    = 8'h15;
  localparam logic [7:0] CMD_JOY_QUERY  = 8'h16;
  localparam logic [7:0] CMD_JOY_MON    = 8'h17;
  localparam logic [7:0] CMD_JOY_FIRE   = 8'h18;
  localparam logic [7:0] CMD_JOY_KEY    = 8'h19;
  localparam logic [7:0] CMD_JOY_OFF    = 8'h1a;
  localparam logic [7:0] CMD_SET_CLOCK  = 8'h1b;
  localparam logic [7:0] CMD_GET_CLOCK  = 8'h1c;
  localparam logic [7:0] CMD_MEM_LOAD   = 8'h20;
  localparam logic [7:0] CMD_MEM_READ   = 8'h21;
  localparam logic [7:0] CMD_EXEC       = 8'h22;
  localparam logic [7:0] CMD_RESET      = 8'h80;
  localparam logic [7:0] CMD_REQ_BTN    = 8'h87;
  localparam logic [7:0] CMD_REQ_MODE0  = 8'h88;
  localparam logic [7:0] CMD_REQ_MODE1  = 8'h89;
  localparam logic [7:0] CMD_REQ_MODE2  = 8'h8a;
  localparam logic [7:0] CMD_REQ_THRESH = 8'h8b;
  localparam logic [7:0] CMD_REQ_SCALE  = 8'h8c;
  localparam logic [7:0] CMD_REQ_YINV0  = 8'h8f;
  localparam logic [7:0] CMD_REQ_YINV1  = 8'h90;
  localparam logic [7:0] CMD_REQ_MOFF   = 8'h92;
  localparam logic [7:0] CMD_REQ_JOY0   = 8'h94;
  localparam logic [7:0] CMD_REQ_JOY1   = 8'h95;
  localparam logic [7:0] CMD_REQ_JOY2   = 8'h99;
  localparam logic [7:0] CMD_REQ_JOYOFF = 8'h9a;

  // reply headers
  localparam logic [7:0] HDR_ABS_POS  = 8'hf7;
  localparam logic [7:0] HDR_JOY      = 8'hfd;
  localparam logic [7:0] HDR_CLOCK    = 8'hfc;
  localparam logic [7:0] HDR_RESET_OK = 8'hf0;
  localparam logic [7:0] HDR_REL      = 8'hf8;
  localparam logic [7:0] HDR_STICK0   = 8'hff;
  localparam logic [7:0] HDR_STICK1   = 8'hfe;

  // one classified event handed from front to back
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  data_byte;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        stick_select;
  } kmc_event_t;

  // queue status toward the front
  typedef struct packed {
    logic full;
    logic empty;
  } kmc_qstat_t;

endpackage

// File: src/kmc_if.sv
interface kmc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  data_byte;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic        stick_select;
  modport source (output valid, func, data_byte, pos_x, pos_y, stick_select, input ready);
  modport sink (input valid, func, data_byte, pos_x, pos_y, stick_select, output ready);
endinterface

interface kmc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       output_paused;
  modport source (output valid, out_byte, last_byte, output_paused, input ready);
  modport sink (input valid, out_byte, last_byte, output_paused, output ready);
endinterface

// File: src/keyboard_mouse_controller_unit.sv
// channel | dir | handshake    | word
// in_ch   | in  | valid/ready  | func, data_byte, pos_x, pos_y, stick_select
// out_ch  | out | valid/ready  | out_byte, last_byte, output_paused
// cfg     | in  | cfg_we       | video_mode (2 bits)
// An event is taken in S_IDLE, then S_SEND puts out the reply bytes one by one and
// returns to S_IDLE once the last byte is accepted; a mouse report first passes
// S_MOUSE for the bounding step. A reply holds up to 7 bytes.
// A two-entry queue lets the input side accept while a burst drains.
// rst is synchronous: clears the control and mode state, the queue pointers and count, and out_ch.valid.
// A stalled out_ch holds the current byte; a full queue drops in_ch.ready.
module keyboard_mouse_controller_unit
  import kmc_pkg::*;
#(
  parameter int unsigned CMD_BUFFER_DEPTH = 10
) (
  input  logic       clk,
  input  logic       rst,
  kmc_in_if.sink     in_ch,
  kmc_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata
);

  logic [1:0]  video_mode;
  logic        push, pop;
  kmc_event_t  push_word, head;
  kmc_qstat_t  qstat;

  // hold the configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      video_mode <= 2'd0;
    end else if (cfg_we) begin
      video_mode <= cfg_wdata;
    end
  end

  kmc_front u_front (
    .clk, .rst, .in_ch, .qstat, .push, .push_word
  );

  kmc_queue u_queue (
    .clk, .rst, .push, .push_word, .pop, .head, .stat(qstat)
  );

  kmc_back #(.CmdDepth(CMD_BUFFER_DEPTH)) u_back (
    .clk, .rst, .video_mode, .head, .head_valid(!qstat.empty), .pop, .out_ch
  );

endmodule

// File: src/kmc_queue.sv
module kmc_queue
  import kmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  kmc_event_t push_word,
  input  logic       pop,
  output kmc_event_t head,
  output kmc_qstat_t stat
);

  localparam int unsigned Depth = 2;

  kmc_event_t  slots [Depth];
  logic        wptr;
  logic        rptr;
  logic [1:0]  count;

  assign head       = slots[rptr];
  assign stat.full  = (count == 2'(Depth));
  assign stat.empty = (count == 2'd0);

  // store incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_word;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!stat.full || pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(Depth)) else $error("queue count out of range");

endmodule

// File: src/kmc_front.sv
module kmc_front
  import kmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  kmc_in_if.sink     in_ch,
  input  kmc_qstat_t qstat,
  output logic       push,
  output kmc_event_t push_word
);

  // classify and drop the key events nothing cares about further: none here,
  // every word goes to the back; front only gates on queue room
  assign in_ch.ready          = !qstat.full;
  assign push                 = in_ch.valid && !qstat.full;
  assign push_word.func         = in_ch.func;
  assign push_word.data_byte    = in_ch.data_byte;
  assign push_word.pos_x        = in_ch.pos_x;
  assign push_word.pos_y        = in_ch.pos_y;
  assign push_word.stick_select = in_ch.stick_select;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full) else $error("push into full queue");

endmodule

// File: src/kmc_back.sv
module kmc_back
  import kmc_pkg::*;
#(
  parameter int unsigned CmdDepth = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  video_mode,
  input  kmc_event_t  head,
  input  logic        head_valid,
  output logic        pop,
  kmc_out_if.source   out_ch
);

  localparam int unsigned CntW = $clog2(CmdDepth + 1);
  localparam int unsigned IdxW = $clog2(CmdDepth);

  typedef enum logic [1:0] {S_IDLE, S_MOUSE, S_SEND} state_t;

  state_t      state;
  logic [7:0]  cmd_bytes [CmdDepth];
  logic [CntW-1:0] cmd_count;
  logic [1:0]  mouse_mode;
  logic [7:0]  button_bits, reported_buttons, action_code;
  logic [15:0] abs_lim0, abs_lim1;
  logic [7:0]  kd0, kd1, th0, th1, sc0, sc1;
  logic [15:0] real_x, real_y, host_x, host_y;
  logic        y_inverted, motion_pending, paused;
  logic [7:0]  stick_mode, stick_rate, stick0, stick1;

  // reply burst buffer
  logic [7:0]  burst [MaxBurst];
  logic [2:0]  blen, bidx;

  // mouse stage registers
  logic signed [8:0] mdx, mdy;
  logic        mclx, mcly;

  // combinational command decode
  logic [CntW-1:0] wpos;
  logic [CntW-1:0] n;
  logic [7:0]  b0, hb;
  logic [7:0]  rep [MaxBurst];
  logic [2:0]  rlen;
  logic        clr;
  logic [1:0]  vm;

  assign vm = (video_mode == 2'd3) ? 2'd2 : video_mode;
  assign hb = head.data_byte;
  assign wpos = (cmd_count >= CntW'(CmdDepth)) ? '0 : cmd_count;
  assign n = wpos + CntW'(1);
  assign b0 = (wpos == '0) ? hb : cmd_bytes[0];

  function automatic logic [7:0] cb(input logic [CntW-1:0] i,
                                    input logic [CntW-1:0] w,
                                    input logic [7:0] nb,
                                    input logic [7:0] c);
    return (i == w) ? nb : c;
  endfunction

  // byte k of the buffer as seen after this write
  logic [7:0] c1, c2, c3, c4, c5;
  assign c1 = cb(CntW'(1), wpos, hb, cmd_bytes[1]);
  assign c2 = cb(CntW'(2), wpos, hb, cmd_bytes[2]);
  assign c3 = cb(CntW'(3), wpos, hb, cmd_bytes[3]);
  assign c4 = cb(CntW'(4), wpos, hb, cmd_bytes[4]);
  assign c5 = cb(CntW'(5), wpos, hb, cmd_bytes[5]);

  // decode reply of a host byte
  always_comb begin
    for (int i = 0; i < MaxBurst; i++) rep[i] = 8'h00;
    rlen = 3'd0;
    clr = 1'b0;
    case (b0)
      CMD_ABS_READ: begin
        clr = 1'b1; rlen = 3'd6;
        rep[0] = HDR_ABS_POS; rep[1] = button_bits;
        rep[2] = real_x[15:8]; rep[3] = real_x[7:0];
        rep[4] = real_y[15:8]; rep[5] = real_y[7:0];
      end
      CMD_JOY_QUERY: begin
        clr = 1'b1; rlen = 3'd3;
        rep[0] = HDR_JOY; rep[1] = stick0; rep[2] = stick1;
      end
      CMD_GET_CLOCK: begin
        clr = 1'b1; rlen = 3'd7; rep[0] = HDR_CLOCK;
      end
      CMD_RESET: begin
        if (n == CntW'(2)) begin
          clr = 1'b1; rlen = 3'd1; rep[0] = HDR_RESET_OK;
        end
      end
      CMD_REQ_BTN: begin
        clr = 1'b1; rlen = 3'd7; rep[0] = CMD_BTN_ACTION; rep[1] = action_code;
      end
      CMD_REQ_MODE0, CMD_REQ_MODE1, CMD_REQ_MODE2: begin
        clr = 1'b1;
        case (mouse_mode)
          MM_REL: begin rlen = 3'd7; rep[0] = CMD_REL_MOUSE; end
          MM_ABS: begin
            rlen = 3'd7; rep[0] = CMD_ABS_MOUSE;
            rep[1] = abs_lim0[15:8]; rep[2] = abs_lim0[7:0];
            rep[3] = abs_lim1[15:8]; rep[4] = abs_lim1[7:0];
          end
          MM_KEY: begin
            rlen = 3'd7; rep[0] = CMD_KEY_MOUSE; rep[1] = kd0; rep[2] = kd1;
          end
          default: rlen = 3'd0;
        endcase
      end
      CMD_REQ_THRESH: begin
        clr = 1'b1; rlen = 3'd7; rep[0] = CMD_THRESH; rep[1] = th0; rep[2] = th1;
      end
      CMD_REQ_SCALE: begin
        clr = 1'b1; rlen = 3'd7; rep[0] = CMD_SCALE; rep[1] = sc0; rep[2] = sc1;
      end
      CMD_REQ_YINV0, CMD_REQ_YINV1: begin
        clr = 1'b1; rlen = 3'd7;
        rep[0] = y_inverted ? CMD_Y_BOTTOM : CMD_Y_TOP;
      end
      CMD_REQ_MOFF: begin
        clr = 1'b1; rlen = 3'd7;
        rep[0] = (mouse_mode != MM_OFF) ? 8'h00 : CMD_MOUSE_OFF;
      end
      CMD_REQ_JOY0, CMD_REQ_JOY1, CMD_REQ_JOY2: begin
        clr = 1'b1;
        if (stick_mode == CMD_JOY_EVENT || stick_mode == CMD_JOY_INT ||
            stick_mode == CMD_JOY_KEY) begin
          rlen = 3'd7; rep[0] = stick_mode;
        end
      end
      CMD_REQ_JOYOFF: begin
        clr = 1'b1; rlen = 3'd7;
        rep[0] = (stick_mode == CMD_JOY_OFF) ? CMD_JOY_OFF : 8'h00;
      end
      CMD_BTN_ACTION, CMD_JOY_MON: clr = (n == CntW'(2));
      CMD_ABS_MOUSE: clr = (n == CntW'(5));
      CMD_KEY_MOUSE, CMD_THRESH, CMD_SCALE: clr = (n == CntW'(3));
      CMD_ABS_LOAD: clr = (n == CntW'(6));
      CMD_JOY_KEY, CMD_SET_CLOCK: clr = (n == CntW'(7));
      CMD_REL_MOUSE, CMD_Y_BOTTOM, CMD_Y_TOP, CMD_RESUME, CMD_MOUSE_OFF,
      CMD_PAUSE, CMD_JOY_EVENT, CMD_JOY_INT, CMD_JOY_FIRE, CMD_JOY_OFF,
      CMD_MEM_LOAD, CMD_MEM_READ, CMD_EXEC: clr = 1'b1;
      default: clr = 1'b0;
    endcase
  end

  // mouse stage: clamp deltas from registered positions
  logic signed [16:0] rdx, rdy;
  logic signed [8:0]  cdx, cdy;
  assign rdx = $signed({1'b0, real_x}) - $signed({1'b0, host_x});
  assign rdy = $signed({1'b0, real_y}) - $signed({1'b0, host_y});
  assign cdx = (rdx > 17'sd127) ? 9'sd127 : (rdx < -17'sd127) ? -9'sd127 : rdx[8:0];
  assign cdy = (rdy > 17'sd127) ? 9'sd127 : (rdy < -17'sd127) ? -9'sd127 : rdy[8:0];

  // second mouse step from registered deltas
  logic [8:0]  ax, ay;
  logic signed [17:0] hx, hy;
  logic [9:0]  xmax, ymax;
  logic        send_pkt;
  logic signed [8:0] fdx, fdy;
  logic [15:0] nhx, nhy;
  assign ax = mdx[8] ? 9'(-mdx) : 9'(mdx);
  assign ay = mdy[8] ? 9'(-mdy) : 9'(mdy);
  assign send_pkt = !(reported_buttons == button_bits && ax <= {1'b0, th0} &&
                      ay <= {1'b0, th1});
  assign hx = $signed({2'b0, host_x}) + 18'(mdx);
  assign hy = $signed({2'b0, host_y}) + 18'(mdy);
  assign xmax = (vm == 2'd0) ? 10'd319 : 10'd639;
  assign ymax = (vm >= 2'd2) ? 10'd399 : 10'd199;
  always_comb begin
    fdx = mdx; fdy = mdy;
    nhx = hx[15:0]; nhy = hy[15:0];
    if (hx <= 18'sd0) begin nhx = '0; fdx = -9'sd127; end
    if (hy <= 18'sd0) begin nhy = '0; fdy = -9'sd127; end
    if (hx >= $signed({8'b0, xmax})) begin nhx = 16'(xmax); fdx = 9'sd127; end
    if (hy >= $signed({8'b0, ymax})) begin nhy = 16'(ymax); fdy = 9'sd127; end
  end

  logic take;
  assign take = (state == S_IDLE) && head_valid;
  assign pop = take;

  logic last_sent;
  assign last_sent = out_ch.valid && out_ch.ready && out_ch.last_byte;

  // stage one step of an event, then drain the burst
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd_count <= '0; mouse_mode <= MM_OFF;
      button_bits <= '0; reported_buttons <= '0; action_code <= '0;
      abs_lim0 <= '0; abs_lim1 <= '0; kd0 <= '0; kd1 <= '0;
      th0 <= '0; th1 <= '0; sc0 <= '0; sc1 <= '0;
      real_x <= '0; real_y <= '0; host_x <= '0; host_y <= '0;
      y_inverted <= 1'b0; motion_pending <= 1'b0; paused <= 1'b0;
      stick_mode <= '0; stick_rate <= '0; stick0 <= '0; stick1 <= '0;
      blen <= '0; bidx <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            bidx <= '0;
            case (head.func)
              FUNC_HOST: begin
                cmd_bytes[wpos[IdxW-1:0]] <= hb;
                cmd_count <= clr ? '0 : n;
                for (int i = 0; i < MaxBurst; i++) burst[i] <= rep[i];
                blen <= rlen;
                if (rlen != 3'd0) state <= S_SEND;
                case (b0)
                  CMD_BTN_ACTION: if (n == CntW'(2)) action_code <= c1;
                  CMD_REL_MOUSE: mouse_mode <= MM_REL;
                  CMD_ABS_MOUSE: if (n == CntW'(5)) begin
                    mouse_mode <= MM_ABS; abs_lim0 <= {c1, c2}; abs_lim1 <= {c3, c4};
                  end
                  CMD_KEY_MOUSE: if (n == CntW'(3)) begin
                    mouse_mode <= MM_KEY; kd0 <= c1; kd1 <= c2;
                  end
                  CMD_THRESH: if (n == CntW'(3)) begin th0 <= c1; th1 <= c2; end
                  CMD_SCALE: if (n == CntW'(3)) begin sc0 <= c1; sc1 <= c2; end
                  CMD_ABS_LOAD: if (n == CntW'(6)) begin
                    real_x <= {c2, c3}; real_y <= {c4, c5};
                  end
                  CMD_Y_BOTTOM: y_inverted <= 1'b1;
                  CMD_Y_TOP: y_inverted <= 1'b0;
                  CMD_RESUME: paused <= 1'b0;
                  CMD_MOUSE_OFF: mouse_mode <= MM_OFF;
                  CMD_PAUSE: paused <= 1'b1;
                  CMD_JOY_EVENT, CMD_JOY_INT, CMD_JOY_FIRE, CMD_JOY_OFF: stick_mode <= b0;
                  CMD_JOY_MON: if (n == CntW'(2)) begin
                    stick_rate <= c1; stick_mode <= CMD_JOY_MON;
                  end
                  CMD_JOY_KEY: if (n == CntW'(7)) stick_mode <= CMD_JOY_KEY;
                  CMD_RESET: if (n == CntW'(2)) begin
                    button_bits <= '0; reported_buttons <= '0;
                    host_x <= (vm == 2'd0) ? 16'd160 : 16'd320;
                    host_y <= (vm >= 2'd2) ? 16'd200 : 16'd100;
                  end
                  CMD_REQ_MODE0, CMD_REQ_MODE1, CMD_REQ_MODE2: mouse_mode <= MM_REL;
                  default: ;
                endcase
              end
              FUNC_MAKE: begin
                burst[0] <= hb; blen <= 3'd1; state <= S_SEND;
              end
              FUNC_BREAK: begin
                burst[0] <= 8'h80 | hb; blen <= 3'd1; state <= S_SEND;
              end
              FUNC_MOTION: begin
                real_x <= (vm == 2'd0) ? {1'b0, head.pos_x[15:1]} : head.pos_x;
                real_y <= (vm <= 2'd1) ? {1'b0, head.pos_y[15:1]} : head.pos_y;
                motion_pending <= 1'b1;
              end
              FUNC_PRESS, FUNC_RELEASE: begin
                button_bits <= (head.func == FUNC_PRESS) ? (button_bits | hb)
                                                         : (button_bits & ~hb);
                motion_pending <= 1'b0;
                if (mouse_mode == MM_REL) state <= S_MOUSE;
              end
              FUNC_STICK: begin
                if ((head.stick_select ? stick1 : stick0) != hb) begin
                  if (head.stick_select) stick1 <= hb; else stick0 <= hb;
                  burst[0] <= head.stick_select ? HDR_STICK1 : HDR_STICK0;
                  burst[1] <= hb; blen <= 3'd2; state <= S_SEND;
                end
              end
              default: begin
                if (motion_pending) begin
                  motion_pending <= 1'b0;
                  if (mouse_mode == MM_REL) state <= S_MOUSE;
                end
              end
            endcase
            if (head.func == FUNC_PRESS || head.func == FUNC_RELEASE ||
                (head.func == FUNC_POLL && motion_pending)) begin
              mdx <= cdx; mdy <= cdy;
              mclx <= (rdx > 17'sd127) || (rdx < -17'sd127);
              mcly <= (rdy > 17'sd127) || (rdy < -17'sd127);
            end
          end
        end
        S_MOUSE: begin
          if (mclx || mcly) motion_pending <= 1'b1;
          if (send_pkt) begin
            reported_buttons <= button_bits;
            host_x <= nhx; host_y <= nhy;
            burst[0] <= HDR_REL | button_bits;
            burst[1] <= fdx[7:0]; burst[2] <= fdy[7:0];
            blen <= 3'd3; bidx <= '0;
            state <= S_SEND;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SEND: begin
          if (!out_ch.valid || out_ch.ready) begin
            if (last_sent) begin
              out_ch.valid <= 1'b0;
              state <= S_IDLE;
            end else begin
              out_ch.valid <= 1'b1;
              out_ch.out_byte <= burst[bidx];
              out_ch.last_byte <= (bidx == blen - 3'd1);
              out_ch.output_paused <= paused;
              bidx <= bidx + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_send_has_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (blen != 3'd0)) else $error("empty burst");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !out_ch.valid) else $error("output valid while idle");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == S_IDLE)) else $error("pop outside idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd_count <= CntW'(CmdDepth)) else $error("command count overrun");

endmodule

// File: verif/kmc_tb_if.sv
`timescale 1ns / 1ps
// Interfaces are defined in src/kmc_if.sv; this file only carries the reply word
// type that the testbench reply queues hold.
package kmc_tb_pkg;
  import kmc_pkg::*;

  // one expected output word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       output_paused;
  } reply_word_t;
endpackage

// File: verif/tb_keyboard_mouse_controller_unit.sv
`timescale 1ns / 1ps
module tb_keyboard_mouse_controller_unit;
  import kmc_pkg::*;
  import kmc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = '0;

  kmc_in_if in_ch ();
  kmc_out_if out_ch ();

  keyboard_mouse_controller_unit uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // controller shadow state
  logic [1:0]  vmode;
  logic [7:0]  cmd_buf [10];
  int unsigned cmd_cnt;
  logic [1:0]  mmode;
  logic [7:0]  btn_bits, btn_rep, btn_act, stick_md, stick_rt;
  logic [15:0] abs_lim [2];
  logic [7:0]  key_dlt [2], thresh [2], scale [2], stick_st [2];
  logic [15:0] real_pos [2], host_pos [2];
  logic        yinv, mpend, pause_flag;

  kmc_event_t  event_q[$];
  reply_word_t reply_q[$];
  reply_word_t burst[$];

  int errors = 0;
  int cycles = 0;
  bit quiet_in = 1'b0, quiet_out = 1'b0;
  bit hold_in = 1'b0;
  bit in_acc = 1'b0;

  task automatic clear_shadow();
    cmd_cnt = 0; mmode = MM_OFF; btn_bits = 0; btn_rep = 0; btn_act = 0;
    stick_md = 0; stick_rt = 0; yinv = 0; mpend = 0; pause_flag = 0;
    for (int i = 0; i < 2; i++) begin
      abs_lim[i] = 0; key_dlt[i] = 0; thresh[i] = 0; scale[i] = 0;
      stick_st[i] = 0; real_pos[i] = 0; host_pos[i] = 0;
    end
    for (int i = 0; i < 10; i++) cmd_buf[i] = 0;
  endtask

  function automatic void put(logic [7:0] b);
    reply_word_t w;
    if (burst.size() < MaxBurst) begin
      w.out_byte = b; w.last_byte = 1'b0; w.output_paused = 1'b0;
      burst.push_back(w);
    end
  endfunction

  function automatic void put_zeros(int n);
    for (int i = 0; i < n; i++) put(8'h00);
  endfunction

  function automatic int limit_delta(int d);
    if (d > 127) begin d = 127; mpend = 1; end
    if (d < -127) begin d = -127; mpend = 1; end
    return d;
  endfunction

  // relative packet with bounding against the screen
  function automatic void report_motion();
    int dx, dy, hx, hy, xmax, ymax;
    mpend = 0;
    if (mmode != MM_REL) return;
    dx = limit_delta(int'(real_pos[0]) - int'(host_pos[0]));
    dy = limit_delta(int'(real_pos[1]) - int'(host_pos[1]));
    if (btn_rep == btn_bits && (dx < 0 ? -dx : dx) <= int'(thresh[0])
        && (dy < 0 ? -dy : dy) <= int'(thresh[1])) return;
    btn_rep = btn_bits;
    hx = int'(host_pos[0]) + dx;
    hy = int'(host_pos[1]) + dy;
    if (hx <= 0) begin hx = 0; dx = -127; end
    if (hy <= 0) begin hy = 0; dy = -127; end
    xmax = (vmode == 0) ? 319 : 639;
    ymax = (vmode >= 2) ? 399 : 199;
    if (hx >= xmax) begin hx = xmax; dx = 127; end
    if (hy >= ymax) begin hy = ymax; dy = 127; end
    host_pos[0] = hx[15:0];
    host_pos[1] = hy[15:0];
    put(HDR_REL | btn_bits);
    put(dx[7:0]);
    put(dy[7:0]);
  endfunction

  function automatic void take_host_byte(logic [7:0] b);
    int unsigned n;
    if (cmd_cnt >= 10) cmd_cnt = 0;
    cmd_buf[cmd_cnt] = b;
    cmd_cnt++;
    n = cmd_cnt;
    case (cmd_buf[0])
      CMD_BTN_ACTION: if (n == 2) begin btn_act = cmd_buf[1]; cmd_cnt = 0; end
      CMD_REL_MOUSE: begin mmode = MM_REL; cmd_cnt = 0; end
      CMD_ABS_MOUSE: if (n == 5) begin
        mmode = MM_ABS;
        abs_lim[0] = {cmd_buf[1], cmd_buf[2]};
        abs_lim[1] = {cmd_buf[3], cmd_buf[4]};
        cmd_cnt = 0;
      end
      CMD_KEY_MOUSE: if (n == 3) begin
        mmode = MM_KEY; key_dlt[0] = cmd_buf[1]; key_dlt[1] = cmd_buf[2]; cmd_cnt = 0;
      end
      CMD_THRESH: if (n == 3) begin
        thresh[0] = cmd_buf[1]; thresh[1] = cmd_buf[2]; cmd_cnt = 0;
      end
      CMD_SCALE: if (n == 3) begin
        scale[0] = cmd_buf[1]; scale[1] = cmd_buf[2]; cmd_cnt = 0;
      end
      CMD_ABS_READ: begin
        cmd_cnt = 0;
        put(HDR_ABS_POS); put(btn_bits);
        put(real_pos[0][15:8]); put(real_pos[0][7:0]);
        put(real_pos[1][15:8]); put(real_pos[1][7:0]);
      end
      CMD_ABS_LOAD: if (n == 6) begin
        real_pos[0] = {cmd_buf[2], cmd_buf[3]};
        real_pos[1] = {cmd_buf[4], cmd_buf[5]};
        cmd_cnt = 0;
      end
      CMD_Y_BOTTOM: begin yinv = 1; cmd_cnt = 0; end
      CMD_Y_TOP: begin yinv = 0; cmd_cnt = 0; end
      CMD_RESUME: begin pause_flag = 0; cmd_cnt = 0; end
      CMD_MOUSE_OFF: begin mmode = MM_OFF; cmd_cnt = 0; end
      CMD_PAUSE: begin pause_flag = 1; cmd_cnt = 0; end
      CMD_JOY_EVENT, CMD_JOY_INT, CMD_JOY_FIRE, CMD_JOY_OFF: begin
        stick_md = cmd_buf[0]; cmd_cnt = 0;
      end
      CMD_JOY_QUERY: begin
        cmd_cnt = 0; put(HDR_JOY); put(stick_st[0]); put(stick_st[1]);
      end
      CMD_JOY_MON: if (n == 2) begin
        stick_rt = cmd_buf[1]; stick_md = CMD_JOY_MON; cmd_cnt = 0;
      end
      CMD_JOY_KEY: if (n == 7) begin stick_md = CMD_JOY_KEY; cmd_cnt = 0; end
      CMD_SET_CLOCK: if (n == 7) cmd_cnt = 0;
      CMD_GET_CLOCK: begin cmd_cnt = 0; put(HDR_CLOCK); put_zeros(6); end
      CMD_MEM_LOAD, CMD_MEM_READ, CMD_EXEC: cmd_cnt = 0;
      CMD_RESET: if (n == 2) begin
        put(HDR_RESET_OK);
        cmd_cnt = 0; btn_bits = 0; btn_rep = 0;
        host_pos[0] = (vmode == 0) ? 16'd160 : 16'd320;
        host_pos[1] = (vmode >= 2) ? 16'd200 : 16'd100;
      end
      CMD_REQ_BTN: begin cmd_cnt = 0; put(CMD_BTN_ACTION); put(btn_act); put_zeros(5); end
      CMD_REQ_MODE0, CMD_REQ_MODE1, CMD_REQ_MODE2: begin
        cmd_cnt = 0;
        if (mmode == MM_REL) begin
          put(CMD_REL_MOUSE); put_zeros(6);
        end else if (mmode == MM_ABS) begin
          put(CMD_ABS_MOUSE);
          put(abs_lim[0][15:8]); put(abs_lim[0][7:0]);
          put(abs_lim[1][15:8]); put(abs_lim[1][7:0]);
          put_zeros(2);
        end else if (mmode == MM_KEY) begin
          put(CMD_KEY_MOUSE); put(key_dlt[0]); put(key_dlt[1]); put_zeros(4);
        end
        mmode = MM_REL;
      end
      CMD_REQ_THRESH: begin
        cmd_cnt = 0; put(CMD_THRESH); put(thresh[0]); put(thresh[1]); put_zeros(4);
      end
      CMD_REQ_SCALE: begin
        cmd_cnt = 0; put(CMD_SCALE); put(scale[0]); put(scale[1]); put_zeros(4);
      end
      CMD_REQ_YINV0, CMD_REQ_YINV1: begin
        cmd_cnt = 0; put(yinv ? CMD_Y_BOTTOM : CMD_Y_TOP); put_zeros(6);
      end
      CMD_REQ_MOFF: begin
        cmd_cnt = 0; put(mmode != MM_OFF ? 8'h00 : CMD_MOUSE_OFF); put_zeros(6);
      end
      CMD_REQ_JOY0, CMD_REQ_JOY1, CMD_REQ_JOY2: begin
        cmd_cnt = 0;
        if (stick_md == CMD_JOY_EVENT || stick_md == CMD_JOY_INT || stick_md == CMD_JOY_KEY)
        begin
          put(stick_md); put_zeros(6);
        end
      end
      CMD_REQ_JOYOFF: begin
        cmd_cnt = 0; put(stick_md == CMD_JOY_OFF ? CMD_JOY_OFF : 8'h00); put_zeros(6);
      end
      default: ;
    endcase
  endfunction

  // expected burst of one accepted event, appended to reply_q
  function automatic void predict_event(kmc_event_t e);
    logic [15:0] px, py;
    burst.delete();
    case (e.func)
      FUNC_HOST: take_host_byte(e.data_byte);
      FUNC_MAKE: put(e.data_byte);
      FUNC_BREAK: put(8'h80 | e.data_byte);
      FUNC_MOTION: begin
        px = (vmode == 0) ? e.pos_x >> 1 : e.pos_x;
        py = (vmode <= 1) ? e.pos_y >> 1 : e.pos_y;
        real_pos[0] = px; real_pos[1] = py; mpend = 1;
      end
      FUNC_PRESS: begin btn_bits |= e.data_byte; report_motion(); end
      FUNC_RELEASE: begin btn_bits &= ~e.data_byte; report_motion(); end
      FUNC_STICK: if (stick_st[e.stick_select] != e.data_byte) begin
        stick_st[e.stick_select] = e.data_byte;
        put(e.stick_select ? HDR_STICK1 : HDR_STICK0);
        put(e.data_byte);
      end
      default: if (mpend) report_motion();
    endcase
    foreach (burst[k]) begin
      burst[k].last_byte = (k == burst.size() - 1);
      burst[k].output_paused = pause_flag;
      reply_q.push_back(burst[k]);
    end
  endfunction

  // driver: present queued events, change at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // hold the current word
    end else if (event_q.size() > 0 && !hold_in && (quiet_in || $urandom_range(99) >= 21))
    begin
      in_ch.valid <= 1'b1;
      {in_ch.func, in_ch.data_byte, in_ch.pos_x, in_ch.pos_y, in_ch.stick_select}
        <= event_q.pop_front();
    end else begin
      in_ch.valid <= 1'b0;
    end
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet_out || ($urandom_range(99) >= 21);
  end

  // predict on accepted input words, check accepted output words
  always @(posedge clk) begin
    reply_word_t want;
    cycles <= cycles + 1;
    in_acc = !rst && in_ch.valid && in_ch.ready;
    if (in_acc)
      predict_event({in_ch.func, in_ch.data_byte, in_ch.pos_x, in_ch.pos_y,
                     in_ch.stick_select});
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected word byte=%h last=%b paused=%b", $time,
                 out_ch.out_byte, out_ch.last_byte, out_ch.output_paused);
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (want.out_byte !== out_ch.out_byte) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                   out_ch.out_byte);
          errors++;
        end
        if (want.last_byte !== out_ch.last_byte) begin
          $display("%0t: last_byte expected %b actual %b", $time, want.last_byte,
                   out_ch.last_byte);
          errors++;
        end
        if (want.output_paused !== out_ch.output_paused) begin
          $display("%0t: output_paused expected %b actual %b", $time,
                   want.output_paused, out_ch.output_paused);
          errors++;
        end
      end
    end
    if (cycles > 400000) begin
      $display("FAIL keyboard_mouse_controller_unit");
      $finish;
    end
  end

  function automatic kmc_event_t make_event(logic [2:0] f, logic [7:0] d);
    kmc_event_t e;
    e.func = f; e.data_byte = d;
    e.pos_x = 16'($urandom_range(65535)); e.pos_y = 16'($urandom_range(65535));
    e.stick_select = 1'($urandom_range(1));
    return e;
  endfunction

  task automatic send_host(logic [7:0] b);
    event_q.push_back(make_event(FUNC_HOST, b));
  endtask

  function automatic kmc_event_t motion_near();
    kmc_event_t e;
    int cx, cy;
    e = make_event(FUNC_MOTION, 8'($urandom_range(255)));
    cx = (vmode == 0) ? 320 : 640;
    cy = (vmode >= 2) ? 400 : 200;
    if ($urandom_range(3) != 0) begin
      e.pos_x = 16'($urandom_range(cx + 300));
      e.pos_y = 16'($urandom_range(cy + 300));
    end
    return e;
  endfunction

  task automatic drain();
    while (event_q.size() > 0 || in_ch.valid || reply_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_video(logic [7:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v[1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    vmode = (v[1:0] == 2'd3) ? 2'd2 : v[1:0];
  endtask

  // a random well-formed command with random content
  task automatic random_command();
    logic [7:0] codes [] = '{CMD_BTN_ACTION, CMD_REL_MOUSE, CMD_ABS_MOUSE, CMD_KEY_MOUSE,
      CMD_THRESH, CMD_SCALE, CMD_ABS_READ, CMD_ABS_LOAD, CMD_Y_BOTTOM, CMD_Y_TOP,
      CMD_RESUME, CMD_MOUSE_OFF, CMD_PAUSE, CMD_JOY_EVENT, CMD_JOY_INT, CMD_JOY_QUERY,
      CMD_JOY_MON, CMD_JOY_FIRE, CMD_JOY_KEY, CMD_JOY_OFF, CMD_SET_CLOCK, CMD_GET_CLOCK,
      CMD_MEM_LOAD, CMD_MEM_READ, CMD_EXEC, CMD_RESET, CMD_REQ_BTN, CMD_REQ_MODE0,
      CMD_REQ_MODE1, CMD_REQ_MODE2, CMD_REQ_THRESH, CMD_REQ_SCALE, CMD_REQ_YINV0,
      CMD_REQ_YINV1, CMD_REQ_MOFF, CMD_REQ_JOY0, CMD_REQ_JOY1, CMD_REQ_JOY2,
      CMD_REQ_JOYOFF};
    logic [7:0] c;
    int args;
    c = codes[$urandom_range(codes.size() - 1)];
    case (c)
      CMD_BTN_ACTION, CMD_JOY_MON, CMD_RESET: args = 1;
      CMD_KEY_MOUSE, CMD_SCALE: args = 2;
      CMD_THRESH: args = $urandom_range(1) ? 2 : 2 + 0;
      CMD_ABS_MOUSE: args = 4;
      CMD_ABS_LOAD: args = 5;
      CMD_JOY_KEY, CMD_SET_CLOCK: args = 6;
      default: args = 0;
    endcase
    send_host(c);
    for (int i = 0; i < args; i++)
      send_host(c == CMD_THRESH ? 8'($urandom_range(40)) : 8'($urandom_range(255)));
  endtask

  initial begin
    clear_shadow();
    vmode = 0;
    in_ch.valid = 1'b0; in_ch.func = '0; in_ch.data_byte = '0;
    in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.stick_select = 1'b0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: every event kind, field extremes, overrun and request replies
    write_video(8'd2);
    event_q.push_back(make_event(FUNC_MAKE, 8'h00));
    event_q.push_back(make_event(FUNC_BREAK, 8'hff));
    event_q.push_back(make_event(FUNC_STICK, 8'hff));
    event_q.push_back(make_event(FUNC_STICK, 8'hff));
    send_host(CMD_REQ_MODE0);               // mouse off: nothing, turns relative on
    send_host(CMD_RESET); send_host(8'h01);
    event_q.push_back(make_event(FUNC_MOTION, 8'h00));
    event_q.push_back(make_event(FUNC_PRESS, 8'h07));
    event_q.push_back(make_event(FUNC_POLL, 8'h00));
    event_q.push_back(make_event(FUNC_RELEASE, 8'hff));
    send_host(CMD_REQ_SCALE); send_host(CMD_KEY_MOUSE); send_host(8'h12);
    send_host(8'h34); send_host(CMD_REQ_MODE1);
    send_host(CMD_PAUSE); send_host(CMD_GET_CLOCK); send_host(CMD_RESUME);
    for (int i = 0; i < 11; i++) send_host(8'h30);   // unknown opener wraps the buffer
    send_host(CMD_JOY_QUERY);
    drain();

    // random phases over every video setting, the unused code among them
    for (int ph = 0; ph < 4; ph++) begin
      write_video(ph == 0 ? 8'd0 : ph == 1 ? 8'd3 : ph == 2 ? 8'd1 : 8'hfe);
      quiet_in = (ph == 1); quiet_out = (ph == 1);
      send_host(CMD_REL_MOUSE);
      send_host(CMD_RESET); send_host(8'h00);
      for (int n = 0; n < 50; n++) begin
        case ($urandom_range(9))
          0, 1: random_command();
          2: event_q.push_back(make_event(3'($urandom_range(7)), 8'($urandom)));
          3, 4: event_q.push_back(motion_near());
          5: event_q.push_back(make_event(FUNC_PRESS, 8'(1 << $urandom_range(7))));
          6: event_q.push_back(make_event(FUNC_RELEASE, 8'($urandom)));
          7: event_q.push_back(make_event(FUNC_POLL, 8'($urandom)));
          8: event_q.push_back(make_event(FUNC_STICK, 8'($urandom)));
          default: event_q.push_back(make_event(3'($urandom_range(1, 2)), 8'($urandom)));
        endcase
        // hold the sender until all replies are back
        if (n == 30) begin
          while (event_q.size() > 0) @(posedge clk);
          hold_in = 1'b1;
          while (in_ch.valid || reply_q.size() > 0) @(posedge clk);
          hold_in = 1'b0;
        end
      end
      drain();
    end
    quiet_in = 1'b0; quiet_out = 1'b0;
    drain();

    if (errors == 0 && reply_q.size() == 0)
      $display("PASS keyboard_mouse_controller_unit");
    else
      $display("FAIL keyboard_mouse_controller_unit");
    $finish;
  end
endmodule
